// ===== hw/rtl/iee_pkg.sv =====
// Package: token, error and pending-operator codes, level record and control structs.
`timescale 1ns / 1ps
package iee_pkg;

  typedef logic [2:0]  op_t;
  typedef logic [2:0]  err_t;
  typedef logic [1:0]  pend_t;
  typedef logic [31:0] word_t;

  localparam op_t OP_NUM    = 3'd0;
  localparam op_t OP_PLUS   = 3'd1;
  localparam op_t OP_MINUS  = 3'd2;
  localparam op_t OP_TIMES  = 3'd3;
  localparam op_t OP_DIVIDE = 3'd4;
  localparam op_t OP_OPEN   = 3'd5;
  localparam op_t OP_CLOSE  = 3'd6;

  localparam err_t ERR_NONE            = 3'd0;
  localparam err_t ERR_MISSING_OPERAND = 3'd1;
  localparam err_t ERR_OPERATOR        = 3'd2;
  localparam err_t ERR_MISSING_CLOSE   = 3'd3;
  localparam err_t ERR_TOO_DEEP        = 3'd4;
  localparam err_t ERR_DIV_ZERO        = 3'd5;

  localparam pend_t PEND_NONE   = 2'd0;
  localparam pend_t PEND_PLUS   = 2'd1;
  localparam pend_t PEND_MINUS  = 2'd2;
  localparam pend_t PEND_TIMES  = 2'd1;
  localparam pend_t PEND_DIVIDE = 2'd2;

  localparam int unsigned DIV_STEPS = 32;

  // One nesting level: running sum, running product, pending operators.
  typedef struct packed {
    word_t sum;
    pend_t addp;
    word_t prod;
    pend_t mulp;
  } level_t;

  typedef struct packed {
    logic  load_opnd;
    logic  load_inner;
    logic  push;
    logic  pop_rd;
    logic  pop_ld;
    logic  set_mul;
    logic  set_add;
    pend_t pend;
    logic  apply_mul;
    logic  apply_copy;
    logic  div_start;
    logic  div_step;
    logic  out_load;
    err_t  err;
  } cmd_t;

  typedef struct packed {
    logic  level_zero;
    logic  level_max;
    pend_t mulp;
    logic  opnd_zero;
    logic  div_last;
  } stat_t;

endpackage

// ===== hw/rtl/iee_tok_if.sv =====
// Interfaces: token channel and result channel.
`timescale 1ns / 1ps
interface iee_tok_if;
  import iee_pkg::*;
  logic  valid;
  logic  ready;
  op_t   op;
  word_t value;
  logic  last_token;
  modport source (output valid, output op, output value, output last_token, input ready);
  modport sink (input valid, input op, input value, input last_token, output ready);
endinterface

interface iee_res_if;
  import iee_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_value;
  err_t  error_code;
  modport source (output valid, output result_value, output error_code, input ready);
  modport sink (input valid, input result_value, input error_code, output ready);
endinterface

// ===== hw/rtl/iee_dp.sv =====
// Datapath: current level registers, level stack memory, multiplier, serial divider.
`timescale 1ns / 1ps
module iee_dp #(
  parameter int MAX_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  iee_pkg::cmd_t  cmd,
  input  iee_pkg::word_t value,
  output iee_pkg::stat_t stat,
  output iee_pkg::word_t result_value,
  output iee_pkg::err_t  error_code
);
  import iee_pkg::*;

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  level_t        cur;
  level_t        rdata;
  level_t        mem [MAX_DEPTH];
  logic [LW-1:0] level;
  logic [LW-1:0] level_dec;
  word_t         opnd;
  word_t         lvl_val;
  logic [31:0]   rem;
  logic [31:0]   quo;
  logic [4:0]    cnt;
  logic [32:0]   trial;
  logic          fits;
  logic [31:0]   rem_next;
  logic [31:0]   quo_next;
  logic [63:0]   mul_full;

  assign level_dec = level - LW'(1);

  always_comb begin
    unique case (cur.addp)
      PEND_PLUS:  lvl_val = cur.sum + cur.prod;
      PEND_MINUS: lvl_val = cur.sum - cur.prod;
      default:    lvl_val = cur.prod;
    endcase
  end

  // restoring division, one quotient bit a step
  always_comb begin
    trial    = {rem, quo[31]};
    fits     = trial >= {1'b0, opnd};
    rem_next = fits ? 32'(trial - {1'b0, opnd}) : trial[31:0];
    quo_next = {quo[30:0], fits};
  end

  assign mul_full = cur.prod * opnd;

  assign stat.level_zero = (level == '0);
  assign stat.level_max  = (level == LW'(MAX_DEPTH));
  assign stat.mulp       = cur.mulp;
  assign stat.opnd_zero  = (opnd == '0);
  assign stat.div_last   = (cnt == 5'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[level[AW-1:0]] <= cur;
    end
    if (cmd.pop_rd) begin
      rdata <= mem[level_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_opnd) opnd <= value;
    if (cmd.load_inner) opnd <= lvl_val;
    if (cmd.div_start) begin
      rem <= '0;
      quo <= cur.prod;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + 5'd1;
    end
    if (cmd.out_load) begin
      result_value <= (cmd.err == ERR_NONE) ? lvl_val : '0;
      error_code   <= cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= '0;
      level <= '0;
    end else if (cmd.out_load) begin
      cur   <= '0;
      level <= '0;
    end else if (cmd.push) begin
      cur   <= '0;
      level <= level + LW'(1);
    end else if (cmd.pop_rd) begin
      level <= level_dec;
    end else if (cmd.pop_ld) begin
      cur <= rdata;
    end else if (cmd.set_mul) begin
      cur.mulp <= cmd.pend;
    end else if (cmd.set_add) begin
      cur.sum  <= lvl_val;
      cur.addp <= cmd.pend;
    end else if (cmd.apply_mul) begin
      cur.prod <= mul_full[31:0];
      cur.mulp <= PEND_NONE;
    end else if (cmd.apply_copy) begin
      cur.prod <= opnd;
      cur.mulp <= PEND_NONE;
    end else if (cmd.div_step && stat.div_last) begin
      cur.prod <= quo_next;
      cur.mulp <= PEND_NONE;
    end
  end

endmodule

// ===== hw/rtl/iee_ctrl.sv =====
// Controller: token decode, parse state and sequencing of datapath operations.
`timescale 1ns / 1ps
module iee_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  iee_pkg::op_t   in_op,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  iee_pkg::stat_t stat,
  output iee_pkg::cmd_t  cmd
);
  import iee_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TAKE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_POP   = 7'b0001000,
    S_POPLD = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   want, want_next;
  logic   fin, fin_next;
  err_t   err, err_next, err_final;
  logic   last_r, last_next;
  logic   active;
  state_t after;

  assign active   = (err == ERR_NONE) && !fin;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign after    = last_r ? S_FIN : S_IDLE;

  always_comb begin
    err_final = err;
    if (active) begin
      if (want) err_final = ERR_MISSING_OPERAND;
      else if (!stat.level_zero) err_final = ERR_MISSING_CLOSE;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    want_next  = want;
    fin_next   = fin;
    err_next   = err;
    last_next  = last_r;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          last_next  = in_last;
          state_next = in_last ? S_FIN : S_IDLE;
          if (active && want) begin
            if (in_op == OP_NUM) begin
              cmd.load_opnd = 1'b1;
              state_next    = S_TAKE;
            end else if (in_op == OP_OPEN) begin
              if (stat.level_max) err_next = ERR_TOO_DEEP;
              else cmd.push = 1'b1;
            end else begin
              err_next = ERR_OPERATOR;
            end
          end else if (active) begin
            priority if (in_op == OP_TIMES || in_op == OP_DIVIDE) begin
              cmd.set_mul = 1'b1;
              cmd.pend    = (in_op == OP_TIMES) ? PEND_TIMES : PEND_DIVIDE;
              want_next   = 1'b1;
            end else if (in_op == OP_PLUS || in_op == OP_MINUS) begin
              cmd.set_add = 1'b1;
              cmd.pend    = (in_op == OP_PLUS) ? PEND_PLUS : PEND_MINUS;
              want_next   = 1'b1;
            end else if (stat.level_zero) begin
              fin_next = 1'b1;
            end else if (in_op == OP_CLOSE) begin
              cmd.load_inner = 1'b1;
              state_next     = S_POP;
            end else begin
              err_next = ERR_MISSING_CLOSE;
            end
          end
        end
      end
      S_POP: begin
        cmd.pop_rd = 1'b1;
        state_next = S_POPLD;
      end
      S_POPLD: begin
        cmd.pop_ld = 1'b1;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        want_next  = 1'b0;
        state_next = after;
        unique case (stat.mulp)
          PEND_TIMES: cmd.apply_mul = 1'b1;
          PEND_DIVIDE: begin
            if (stat.opnd_zero) begin
              err_next  = ERR_DIV_ZERO;
              want_next = want;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          default: cmd.apply_copy = 1'b1;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = after;
      end
      S_FIN: begin
        cmd.out_load = 1'b1;
        cmd.err      = err_final;
        want_next    = 1'b1;
        fin_next     = 1'b0;
        err_next     = ERR_NONE;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      want   <= 1'b1;
      fin    <= 1'b0;
      err    <= ERR_NONE;
      last_r <= 1'b0;
    end else begin
      state  <= state_next;
      want   <= want_next;
      fin    <= fin_next;
      err    <= err_next;
      last_r <= last_next;
    end
  end

endmodule

// ===== hw/rtl/infix_expression_evaluator.sv =====
// Top level: infix expression evaluator, controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   tok carries one token per transfer: op (number, + - * /, open, close),
//   value (used for numbers) and last_token. res carries one result per
//   expression, result_value and error_code, on the token flagged last.
//   Tokens are handled one at a time; tok.ready is high only while idle.
// Steps per token:
//   operators, open and tokens after an end or error: handled in S_IDLE.
//   number: operand load, then multiply or copy in S_TAKE; with a pending
//   divide, the 32-step serial divider runs in S_DIV instead.
//   close: inner value load, stack memory read (S_POP), load of the popped
//   level (S_POPLD), then as for a number.
//   last token: result formed in S_FIN, then res.valid rises in S_OUT.
// Stall: the result register holds while res.ready is low and no token is
//   taken until that transfer completes.
// Reset: rst (synchronous) returns the parser to an empty expression; the
//   level stack needs no clearing, since a level is written on open before
//   it is ever read back on close.
module infix_expression_evaluator #(
  parameter int MAX_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  iee_tok_if.sink  tok,
  iee_res_if.source res
);
  import iee_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing and parse state
  iee_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tok.valid),
    .in_op     (tok.op),
    .in_last   (tok.last_token),
    .in_ready  (tok.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // levels, arithmetic and result register
  iee_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (tok.value),
    .stat         (stat),
    .result_value (res.result_value),
    .error_code   (res.error_code)
  );

endmodule
